/* hdl/fdd_pkg.sv */
// Package for the finite-difference derivative core: field widths, arithmetic
// constants, item kinds and the structs shared between the modules.
// No dependencies.
package fdd_pkg;

  localparam int unsigned SAMPLE_W   = 32;
  localparam int unsigned K_W        = 32;
  localparam int unsigned IDX_W      = 16;
  localparam int unsigned SUM_W      = 39;
  localparam int unsigned MAG_W      = 38;
  localparam int unsigned MAG_LO_W   = 32;
  localparam int unsigned FRAC_W     = 16;
  localparam int unsigned P_W        = 70;
  localparam int unsigned X_W        = 54;
  localparam int unsigned Y_W        = 33;
  localparam int unsigned RECIP3_W   = 34;
  localparam int unsigned RECIP3_SH  = 35;
  localparam int unsigned PROD3_W    = 67;
  localparam int unsigned SCALE_LAT  = 6;
  localparam int unsigned WIN_DEPTH  = 5;
  localparam int unsigned OUT_DATA_W = 80;

  localparam logic [RECIP3_W-1:0] RECIP3 = 34'h2_AAAA_AAAB;
  localparam logic [K_W-1:0]      ONE_Q16 = 32'h0001_0000;

  localparam logic [X_W-1:0] LIM_POS  = 54'h0000_7FFF_FFFF;
  localparam logic [X_W-1:0] LIM_NEG  = 54'h0000_8000_0000;
  localparam logic [X_W-1:0] LIM3_POS = 54'd6442450944;
  localparam logic [X_W-1:0] LIM3_NEG = 54'd6442450947;

  localparam logic [P_W-1:0] RND_DIV1  = 70'd32768;
  localparam logic [P_W-1:0] RND_DIV2  = 70'd65536;
  localparam logic [P_W-1:0] RND_DIV12 = 70'd393216;

  typedef enum logic [0:0] {
    REG_INV_STEP    = 1'b0,
    REG_INV_STEP_SQ = 1'b1
  } reg_idx_e;

  typedef enum logic [1:0] {
    DIV_1  = 2'd0,
    DIV_2  = 2'd1,
    DIV_12 = 2'd2
  } div_e;

  typedef enum logic [2:0] {
    JOB_FWD   = 3'd0,
    JOB_CEN_S = 3'd1,
    JOB_INT   = 3'd2,
    JOB_CEN_E = 3'd3,
    JOB_BWD   = 3'd4,
    JOB_ERR   = 3'd5
  } job_kind_e;

  typedef enum logic [2:0] {
    FL_IDLE = 3'b001,
    FL_CEN  = 3'b010,
    FL_BWD  = 3'b100
  } flush_e;

  typedef struct packed {
    logic shift;
    logic clear;
  } cell_ctl_t;

  typedef struct packed {
    logic [IDX_W-1:0] idx;
    logic             last;
    logic             short_seq;
  } meta_t;

endpackage

/* hdl/fdd_cell.sv */
// One tap of the sample window: holds a sample and passes it on to its
// neighbour on every shift. Depends on fdd_pkg.
module fdd_cell (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  fdd_pkg::cell_ctl_t            ctl_i,
  input  logic [fdd_pkg::SAMPLE_W-1:0]  din_i,
  output logic [fdd_pkg::SAMPLE_W-1:0]  q_o
);

  logic [fdd_pkg::SAMPLE_W-1:0] val_q, val_d;

  always_comb begin
    val_d = val_q;
    if (ctl_i.shift) begin
      val_d = din_i;
    end else if (ctl_i.clear) begin
      val_d = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      val_q <= '0;
    end else begin
      val_q <= val_d;
    end
  end

  assign q_o = val_q;

endmodule

/* hdl/fdd_scale.sv */
// Scaling unit: multiplies a stencil sum by a Q16.16 factor, divides by
// 65536 times 1, 2 or 12, rounds half away from zero and saturates.
// Six register stages. Depends on fdd_pkg.
module fdd_scale (
  input  logic                              clk_i,
  input  logic                              en_i,
  input  logic signed [fdd_pkg::SUM_W-1:0]  num_i,
  input  fdd_pkg::div_e                     div_i,
  input  logic [fdd_pkg::K_W-1:0]           k_i,
  output logic [fdd_pkg::SAMPLE_W-1:0]      res_o
);

  logic                          neg_a_q, neg_b_q, neg_c_q, neg_d_q, neg_e_q;
  fdd_pkg::div_e                 div_a_q, div_b_q, div_c_q, div_d_q;
  logic [fdd_pkg::MAG_W-1:0]     mag_a_q;
  logic [2*fdd_pkg::K_W-1:0]     p0_b_q;
  logic [fdd_pkg::MAG_W-1:0]     p1_b_q;
  logic [fdd_pkg::X_W-1:0]       x_c_q;
  logic [fdd_pkg::Y_W-1:0]       y_d_q;
  logic                          sat_d_q, sat_e_q;
  logic [fdd_pkg::SAMPLE_W-1:0]  q_e_q, res_f_q;

  logic [fdd_pkg::SUM_W-1:0]     abs_v;
  logic [fdd_pkg::P_W-1:0]       rnd_v, p_v;
  logic [fdd_pkg::X_W-1:0]       y_v, lim_v, lim3_v;
  logic                          sat_v;
  logic [fdd_pkg::PROD3_W-1:0]   prod_v;
  logic [fdd_pkg::SAMPLE_W-1:0]  q_v, lim32_v, mag_f_v;

  assign abs_v = num_i[fdd_pkg::SUM_W-1] ? -num_i : num_i;

  always_comb begin
    case (div_b_q)
      fdd_pkg::DIV_1:  rnd_v = fdd_pkg::RND_DIV1;
      fdd_pkg::DIV_2:  rnd_v = fdd_pkg::RND_DIV2;
      fdd_pkg::DIV_12: rnd_v = fdd_pkg::RND_DIV12;
      default:         rnd_v = fdd_pkg::RND_DIV1;
    endcase
  end

  assign p_v = {p1_b_q, {fdd_pkg::MAG_LO_W{1'b0}}}
             + fdd_pkg::P_W'(p0_b_q) + rnd_v;

  assign lim_v  = neg_c_q ? fdd_pkg::LIM_NEG  : fdd_pkg::LIM_POS;
  assign lim3_v = neg_c_q ? fdd_pkg::LIM3_NEG : fdd_pkg::LIM3_POS;

  always_comb begin
    case (div_c_q)
      fdd_pkg::DIV_1: begin
        y_v   = x_c_q;
        sat_v = y_v > lim_v;
      end
      fdd_pkg::DIV_2: begin
        y_v   = x_c_q >> 1;
        sat_v = y_v > lim_v;
      end
      fdd_pkg::DIV_12: begin
        y_v   = x_c_q >> 2;
        sat_v = y_v >= lim3_v;
      end
      default: begin
        y_v   = x_c_q;
        sat_v = y_v > lim_v;
      end
    endcase
  end

  assign prod_v = fdd_pkg::PROD3_W'(y_d_q) * fdd_pkg::PROD3_W'(fdd_pkg::RECIP3);
  assign q_v    = (div_d_q == fdd_pkg::DIV_12)
                ? prod_v[fdd_pkg::RECIP3_SH +: fdd_pkg::SAMPLE_W]
                : y_d_q[fdd_pkg::SAMPLE_W-1:0];

  assign lim32_v = neg_e_q ? 32'h8000_0000 : 32'h7FFF_FFFF;
  assign mag_f_v = sat_e_q ? lim32_v : q_e_q;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      neg_a_q <= num_i[fdd_pkg::SUM_W-1];
      mag_a_q <= abs_v[fdd_pkg::MAG_W-1:0];
      div_a_q <= div_i;

      neg_b_q <= neg_a_q;
      div_b_q <= div_a_q;
      p0_b_q  <= mag_a_q[fdd_pkg::MAG_LO_W-1:0] * k_i;
      p1_b_q  <= mag_a_q[fdd_pkg::MAG_W-1:fdd_pkg::MAG_LO_W] * k_i;

      neg_c_q <= neg_b_q;
      div_c_q <= div_b_q;
      x_c_q   <= p_v[fdd_pkg::P_W-1:fdd_pkg::FRAC_W];

      neg_d_q <= neg_c_q;
      div_d_q <= div_c_q;
      sat_d_q <= sat_v;
      y_d_q   <= y_v[fdd_pkg::Y_W-1:0];

      neg_e_q <= neg_d_q;
      sat_e_q <= sat_d_q;
      q_e_q   <= q_v;

      res_f_q <= neg_e_q ? -mag_f_v : mag_f_v;
    end
  end

  assign res_o = res_f_q;

endmodule

/* hdl/finite_difference_derivatives_core.sv */
// Top level of the finite-difference derivative core: sample window cells,
// flush sequencer, stencil sums and two scaling units.
// Depends on fdd_pkg, fdd_cell and fdd_scale.
//
//   Channel   Direction  Handshake                      Content
//   s_axis    in         s_axis_tvalid/s_axis_tready    sample, tlast = is_last
//   m_axis    out        m_axis_tvalid/m_axis_tready    index and derivatives,
//                                                       tlast, tuser = too_short
//   cfg       in         cfg_valid_i/cfg_ready_o        register index and data
//
// One sample item is taken per cycle unless a flush or a stalled m_axis
// holds s_axis_tready low. Each result passes a job stage, a stencil stage
// and the six-stage scaler. A last item of a sequence of four or more
// samples holds s_axis_tready low while the window produces the two end
// results. A stalled m_axis freezes the whole pipeline and the input side
// with it. Reset clears the window, the sample count and all valid flags.
module finite_difference_derivatives_core #(
  parameter int unsigned MAX_LEN = 65536
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              s_axis_tvalid,
  output logic                              s_axis_tready,
  input  logic [fdd_pkg::SAMPLE_W-1:0]      s_axis_tdata,  // [31:0] sample
  input  logic                              s_axis_tlast,
  output logic                              m_axis_tvalid,
  input  logic                              m_axis_tready,
  // [15:0] sample_index, [47:16] first_deriv, [79:48] second_deriv
  output logic [fdd_pkg::OUT_DATA_W-1:0]    m_axis_tdata,
  output logic                              m_axis_tlast,
  output logic                              m_axis_tuser,  // [0] too_short
  input  logic                              cfg_valid_i,
  output logic                              cfg_ready_o,
  input  logic [0:0]                        cfg_index_i,
  input  logic [fdd_pkg::K_W-1:0]           cfg_data_i
);

  localparam int unsigned CW  = $clog2(MAX_LEN + 1);
  localparam int unsigned LAT = fdd_pkg::SCALE_LAT;
  localparam int unsigned SW  = fdd_pkg::SAMPLE_W;
  localparam int unsigned NW  = fdd_pkg::SUM_W;

  logic [fdd_pkg::K_W-1:0] inv_step_q, inv_step_sq_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      inv_step_q    <= fdd_pkg::ONE_Q16;
      inv_step_sq_q <= fdd_pkg::ONE_Q16;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        fdd_pkg::REG_INV_STEP:    inv_step_q    <= cfg_data_i;
        fdd_pkg::REG_INV_STEP_SQ: inv_step_sq_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  assign cfg_ready_o = 1'b1;

  logic                        run, acc, leave_clr;
  logic [CW-1:0]               cnt_q, cnt_d, pos;
  fdd_pkg::flush_e             fl_q, fl_d;
  fdd_pkg::cell_ctl_t          cell_ctl;
  logic [SW-1:0]               cell_din [fdd_pkg::WIN_DEPTH];
  logic [SW-1:0]               cell_q   [fdd_pkg::WIN_DEPTH];

  logic                        v1_q, v1_d;
  fdd_pkg::job_kind_e          kind1_q, kind1_d;
  logic [fdd_pkg::IDX_W-1:0]   idx1_q, idx1_d;
  logic                        last1_q, last1_d, clr1_q, clr1_d;

  assign run           = !m_axis_tvalid || m_axis_tready;
  assign s_axis_tready = run && (fl_q == fdd_pkg::FL_IDLE);
  assign acc           = s_axis_tvalid && s_axis_tready;
  assign leave_clr     = run && v1_q && clr1_q;
  assign pos           = leave_clr ? '0 : cnt_q;

  assign cell_ctl.shift = acc;
  assign cell_ctl.clear = leave_clr;

  for (genvar i = 0; i < fdd_pkg::WIN_DEPTH; i++) begin : g_win
    if (i == fdd_pkg::WIN_DEPTH - 1) begin : g_head
      assign cell_din[i] = s_axis_tdata;
    end else begin : g_body
      assign cell_din[i] = leave_clr ? '0 : cell_q[i+1];
    end
    fdd_cell u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .ctl_i  (cell_ctl),
      .din_i  (cell_din[i]),
      .q_o    (cell_q[i])
    );
  end

  always_comb begin
    cnt_d = cnt_q;
    if (acc) begin
      cnt_d = (pos == CW'(MAX_LEN)) ? pos : pos + CW'(1);
    end else if (leave_clr) begin
      cnt_d = '0;
    end
  end

  always_comb begin
    v1_d    = 1'b0;
    kind1_d = kind1_q;
    idx1_d  = idx1_q;
    last1_d = 1'b0;
    clr1_d  = 1'b0;
    fl_d    = fl_q;
    if (acc) begin
      fl_d = fdd_pkg::FL_IDLE;
      if (s_axis_tlast && pos < CW'(3)) begin
        v1_d    = 1'b1;
        kind1_d = fdd_pkg::JOB_ERR;
        idx1_d  = '0;
        last1_d = 1'b1;
        clr1_d  = 1'b1;
      end else if (pos >= CW'(2)) begin
        v1_d   = 1'b1;
        idx1_d = fdd_pkg::IDX_W'(pos - CW'(2));
        if (pos == CW'(2)) begin
          kind1_d = fdd_pkg::JOB_FWD;
        end else if (pos == CW'(3)) begin
          kind1_d = fdd_pkg::JOB_CEN_S;
        end else begin
          kind1_d = fdd_pkg::JOB_INT;
        end
        if (s_axis_tlast) begin
          fl_d = fdd_pkg::FL_CEN;
        end
      end
    end else begin
      case (fl_q)
        fdd_pkg::FL_CEN: begin
          v1_d    = 1'b1;
          kind1_d = fdd_pkg::JOB_CEN_E;
          idx1_d  = idx1_q + fdd_pkg::IDX_W'(1);
          fl_d    = fdd_pkg::FL_BWD;
        end
        fdd_pkg::FL_BWD: begin
          v1_d    = 1'b1;
          kind1_d = fdd_pkg::JOB_BWD;
          idx1_d  = idx1_q + fdd_pkg::IDX_W'(1);
          last1_d = 1'b1;
          clr1_d  = 1'b1;
          fl_d    = fdd_pkg::FL_IDLE;
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
      fl_q  <= fdd_pkg::FL_IDLE;
      v1_q  <= 1'b0;
    end else begin
      cnt_q <= cnt_d;
      if (run) begin
        fl_q <= fl_d;
        v1_q <= v1_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (run) begin
      kind1_q <= kind1_d;
      idx1_q  <= idx1_d;
      last1_q <= last1_d;
      clr1_q  <= clr1_d;
    end
  end

  // Stencil sums over the window; w4 is the newest sample.
  logic signed [NW-1:0] w0, w1, w2, w3, w4, n1_v, n2_v, end2_v;
  fdd_pkg::div_e        d1_v, d2_v;

  assign w0 = {{(NW-SW){cell_q[0][SW-1]}}, cell_q[0]};
  assign w1 = {{(NW-SW){cell_q[1][SW-1]}}, cell_q[1]};
  assign w2 = {{(NW-SW){cell_q[2][SW-1]}}, cell_q[2]};
  assign w3 = {{(NW-SW){cell_q[3][SW-1]}}, cell_q[3]};
  assign w4 = {{(NW-SW){cell_q[4][SW-1]}}, cell_q[4]};
  assign end2_v = w4 - (w3 <<< 1) + w2;

  always_comb begin
    case (kind1_q)
      fdd_pkg::JOB_FWD: begin
        n1_v = w3 - w2;
        d1_v = fdd_pkg::DIV_1;
        n2_v = end2_v;
        d2_v = fdd_pkg::DIV_2;
      end
      fdd_pkg::JOB_CEN_S: begin
        n1_v = w3 - w1;
        d1_v = fdd_pkg::DIV_2;
        n2_v = w3 - (w2 <<< 1) + w1;
        d2_v = fdd_pkg::DIV_1;
      end
      fdd_pkg::JOB_INT: begin
        n1_v = (w3 <<< 3) - (w1 <<< 3) - w4 + w0;
        d1_v = fdd_pkg::DIV_12;
        n2_v = (w3 <<< 4) + (w1 <<< 4) - (w2 <<< 5) + (w2 <<< 1) - w4 - w0;
        d2_v = fdd_pkg::DIV_12;
      end
      fdd_pkg::JOB_CEN_E: begin
        n1_v = w4 - w2;
        d1_v = fdd_pkg::DIV_2;
        n2_v = end2_v;
        d2_v = fdd_pkg::DIV_1;
      end
      fdd_pkg::JOB_BWD: begin
        n1_v = w4 - w3;
        d1_v = fdd_pkg::DIV_1;
        n2_v = end2_v;
        d2_v = fdd_pkg::DIV_2;
      end
      default: begin
        n1_v = '0;
        d1_v = fdd_pkg::DIV_1;
        n2_v = '0;
        d2_v = fdd_pkg::DIV_1;
      end
    endcase
  end

  logic                  v2_q;
  logic signed [NW-1:0]  n1_q, n2_q;
  fdd_pkg::div_e         d1_q, d2_q;
  fdd_pkg::meta_t        meta2_q;
  logic [LAT-1:0]        pipe_v_q;
  fdd_pkg::meta_t        pipe_m_q [LAT];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v2_q     <= 1'b0;
      pipe_v_q <= '0;
    end else if (run) begin
      v2_q     <= v1_q;
      pipe_v_q <= {pipe_v_q[LAT-2:0], v2_q};
    end
  end

  always_ff @(posedge clk_i) begin
    if (run) begin
      n1_q              <= n1_v;
      n2_q              <= n2_v;
      d1_q              <= d1_v;
      d2_q              <= d2_v;
      meta2_q.idx       <= idx1_q;
      meta2_q.last      <= last1_q;
      meta2_q.short_seq <= (kind1_q == fdd_pkg::JOB_ERR);
      pipe_m_q[0]       <= meta2_q;
      for (int i = 1; i < LAT; i++) begin
        pipe_m_q[i] <= pipe_m_q[i-1];
      end
    end
  end

  logic [SW-1:0] first_res, second_res;

  fdd_scale u_scale_first (
    .clk_i (clk_i),
    .en_i  (run),
    .num_i (n1_q),
    .div_i (d1_q),
    .k_i   (inv_step_q),
    .res_o (first_res)
  );

  fdd_scale u_scale_second (
    .clk_i (clk_i),
    .en_i  (run),
    .num_i (n2_q),
    .div_i (d2_q),
    .k_i   (inv_step_sq_q),
    .res_o (second_res)
  );

  assign m_axis_tvalid = pipe_v_q[LAT-1];
  assign m_axis_tdata  = {second_res, first_res, pipe_m_q[LAT-1].idx};
  assign m_axis_tlast  = pipe_m_q[LAT-1].last;
  assign m_axis_tuser  = pipe_m_q[LAT-1].short_seq;

  a_short_result_empty : assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tuser |-> m_axis_tlast && (m_axis_tdata[79:16] == '0))
    else $error("short-sequence result carries data or lacks last");

  a_flush_blocks_input : assert property (@(posedge clk_i) disable iff (!rst_ni)
    acc && s_axis_tlast && (pos >= CW'(3)) |=> !s_axis_tready)
    else $error("input taken while end results are still due");

  a_clear_window : assert property (@(posedge clk_i) disable iff (!rst_ni)
    leave_clr && !acc |=> (cnt_q == '0) && (cell_q[4] == '0) && (cell_q[2] == '0))
    else $error("window not cleared after the final item of a sequence");

  a_no_clear_in_flush : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (fl_q != fdd_pkg::FL_IDLE) |-> !(v1_q && clr1_q))
    else $error("window clear scheduled before the end results");

endmodule
